// ===== rtl/prime_count_trial_division_macros.svh =====
// Assertion macros for the strided prime counter checker.
// Needs nothing else; included by the checker file only.
`ifndef PRIME_COUNT_TRIAL_DIVISION_MACROS_SVH
`define PRIME_COUNT_TRIAL_DIVISION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCTD_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCTD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pctd_pkg.sv =====
// Shared types, constants and microcode ROM of the strided prime counter.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package pctd_pkg;

	localparam int unsigned VALUE_BITS_DEF = 20;
	localparam int unsigned COUNT_BITS     = 20;
	localparam int unsigned OUT_DATA_BITS  = ((COUNT_BITS + 7) / 8) * 8;
	localparam int unsigned STEP_W         = 4;

	// microprogram addresses
	localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
	localparam logic [STEP_W-1:0] STEP_TEST_END = 4'd1;
	localparam logic [STEP_W-1:0] STEP_LT2      = 4'd2;
	localparam logic [STEP_W-1:0] STEP_LT4      = 4'd3;
	localparam logic [STEP_W-1:0] STEP_EVEN     = 4'd4;
	localparam logic [STEP_W-1:0] STEP_LOOP     = 4'd5;
	localparam logic [STEP_W-1:0] STEP_MOD      = 4'd6;
	localparam logic [STEP_W-1:0] STEP_MOD_CHK  = 4'd7;
	localparam logic [STEP_W-1:0] STEP_NEXT     = 4'd8;
	localparam logic [STEP_W-1:0] STEP_PRIME    = 4'd9;
	localparam logic [STEP_W-1:0] STEP_DONE     = 4'd10;

	typedef enum logic [3:0] {
		COND_ALWAYS   = 4'd0,
		COND_IN_VALID = 4'd1,
		COND_GE_LIMIT = 4'd2,
		COND_LT2      = 4'd3,
		COND_LT4      = 4'd4,
		COND_EVEN     = 4'd5,
		COND_SQ_GT    = 4'd6,
		COND_BIT_NZ   = 4'd7,
		COND_REM_NZ   = 4'd8,
		COND_OUT_BUSY = 4'd9
	} cond_t;

	typedef enum logic [3:0] {
		OP_NONE     = 4'd0,
		OP_LOAD     = 4'd1,
		OP_INIT_DIV = 4'd2,
		OP_INIT_MOD = 4'd3,
		OP_MOD_STEP = 4'd4,
		OP_NEXT_DIV = 4'd5,
		OP_COUNT    = 4'd6,
		OP_ADVANCE  = 4'd7,
		OP_EMIT     = 4'd8
	} op_t;

	typedef struct packed {
		cond_t             cond;
		logic [STEP_W-1:0] t_true;
		logic [STEP_W-1:0] t_false;
		op_t               op;
	} ucode_t;

	function automatic ucode_t ucode_fetch(input logic [STEP_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			STEP_IDLE:     w = '{COND_IN_VALID, STEP_TEST_END, STEP_IDLE,     OP_LOAD};
			STEP_TEST_END: w = '{COND_GE_LIMIT, STEP_DONE,     STEP_LT2,      OP_NONE};
			STEP_LT2:      w = '{COND_LT2,      STEP_NEXT,     STEP_LT4,      OP_NONE};
			STEP_LT4:      w = '{COND_LT4,      STEP_PRIME,    STEP_EVEN,     OP_NONE};
			STEP_EVEN:     w = '{COND_EVEN,     STEP_NEXT,     STEP_LOOP,     OP_INIT_DIV};
			STEP_LOOP:     w = '{COND_SQ_GT,    STEP_PRIME,    STEP_MOD,      OP_INIT_MOD};
			STEP_MOD:      w = '{COND_BIT_NZ,   STEP_MOD,      STEP_MOD_CHK,  OP_MOD_STEP};
			STEP_MOD_CHK:  w = '{COND_REM_NZ,   STEP_LOOP,     STEP_NEXT,     OP_NEXT_DIV};
			STEP_NEXT:     w = '{COND_ALWAYS,   STEP_TEST_END, STEP_TEST_END, OP_ADVANCE};
			STEP_PRIME:    w = '{COND_ALWAYS,   STEP_NEXT,     STEP_NEXT,     OP_COUNT};
			STEP_DONE:     w = '{COND_OUT_BUSY, STEP_DONE,     STEP_IDLE,     OP_EMIT};
			default:       w = '{COND_ALWAYS,   STEP_IDLE,     STEP_IDLE,     OP_NONE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/prime_count_trial_division.sv =====
// Strided prime counter, trial division under a microcoded sequencer.
// Each accepted walk runs the sequencer per candidate: range check, small and even tests, then
// odd trial divisors 3,5,7.. tested up to the square root by the bit-serial remainder unit.
// One transaction at a time: s_tready stays low until the result has been emitted.
// Reset: arst_n asynchronous, active low; clears sequencer and output valid only.
`timescale 1ns / 1ps
`default_nettype none

module prime_count_trial_division #(
	parameter int unsigned VALUE_BITS = pctd_pkg::VALUE_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// slave side
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// s_tdata: start_value, limit_value, stride (lowest first), zero pad to bytes
	input  wire logic [((3*VALUE_BITS+7)/8)*8-1:0]      s_tdata,
	// master side
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// m_tdata: prime_count, zero pad to bytes
	output logic [pctd_pkg::OUT_DATA_BITS-1:0]          m_tdata
);
	import pctd_pkg::*;

	localparam int unsigned CAND_W = VALUE_BITS + 1;   // candidate never wraps
	localparam int unsigned SQ_W   = VALUE_BITS + 2;   // running divisor square
	localparam int unsigned BIT_W  = $clog2(CAND_W);
	localparam int unsigned PAD_W  = OUT_DATA_BITS - COUNT_BITS;

	// sequencer
	logic [STEP_W-1:0]     pc_q;
	ucode_t                uc;
	logic                  cond_hit;

	// datapath registers (no reset needed: loaded before use)
	logic [CAND_W-1:0]     cand_q;
	logic [VALUE_BITS-1:0] limit_q;
	logic [VALUE_BITS-1:0] stride_q;
	logic [VALUE_BITS-1:0] div_q;
	logic [SQ_W-1:0]       sq_q;
	logic [CAND_W-1:0]     rem_q;
	logic [BIT_W-1:0]      bit_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] out_q;
	logic                  m_valid_q;

	// input field split
	logic [VALUE_BITS-1:0] in_start;
	logic [VALUE_BITS-1:0] in_limit;
	logic [VALUE_BITS-1:0] in_stride;

	// remainder unit: one restoring step per cycle
	logic [CAND_W-1:0]     rem_sh;
	logic [CAND_W-1:0]     rem_nx;
	logic                  out_busy;

	assign in_start  = s_tdata[VALUE_BITS-1:0];
	assign in_limit  = s_tdata[2*VALUE_BITS-1:VALUE_BITS];
	assign in_stride = s_tdata[3*VALUE_BITS-1:2*VALUE_BITS];

	assign uc       = ucode_fetch(pc_q);
	assign out_busy = m_valid_q && !m_tready;

	assign s_tready = (pc_q == STEP_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_q};

	assign rem_sh = {rem_q[VALUE_BITS-1:0], cand_q[bit_q]};
	assign rem_nx = (rem_sh >= {1'b0, div_q}) ? (rem_sh - {1'b0, div_q}) : rem_sh;

	// branch condition select
	always_comb begin
		unique case (uc.cond)
			COND_ALWAYS:   cond_hit = 1'b1;
			COND_IN_VALID: cond_hit = s_tvalid;
			COND_GE_LIMIT: cond_hit = (cand_q >= {1'b0, limit_q});
			COND_LT2:      cond_hit = (cand_q < CAND_W'(2));
			COND_LT4:      cond_hit = (cand_q < CAND_W'(4));
			COND_EVEN:     cond_hit = !cand_q[0];
			COND_SQ_GT:    cond_hit = (sq_q > {1'b0, cand_q});
			COND_BIT_NZ:   cond_hit = (bit_q != '0);
			COND_REM_NZ:   cond_hit = (rem_q != '0);
			COND_OUT_BUSY: cond_hit = out_busy;
			default:       cond_hit = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= cond_hit ? uc.t_true : uc.t_false;
		end
	end

	// output register: cleared on take, loaded by the emit step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (uc.op == OP_EMIT && !out_busy) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// datapath driven by the control word
	always_ff @(posedge clk) begin
		unique case (uc.op)
			OP_LOAD: begin
				if (s_tvalid) begin
					cand_q   <= {1'b0, in_start};
					limit_q  <= in_limit;
					// zero stride walks as stride one
					stride_q <= (in_stride == '0) ? VALUE_BITS'(1) : in_stride;
					count_q  <= '0;
				end
			end
			OP_INIT_DIV: begin
				div_q <= VALUE_BITS'(3);
				sq_q  <= SQ_W'(9);
			end
			OP_INIT_MOD: begin
				rem_q <= '0;
				bit_q <= BIT_W'(VALUE_BITS - 1);
			end
			OP_MOD_STEP: begin
				rem_q <= rem_nx;
				bit_q <= bit_q - BIT_W'(1);
			end
			OP_NEXT_DIV: begin
				// (d+2)^2 = d^2 + 4d + 4
				div_q <= div_q + VALUE_BITS'(2);
				sq_q  <= sq_q + {div_q, 2'b00} + SQ_W'(4);
			end
			OP_COUNT: begin
				count_q <= count_q + COUNT_BITS'(1);
			end
			OP_ADVANCE: begin
				cand_q <= cand_q + {1'b0, stride_q};
			end
			OP_EMIT: begin
				if (!out_busy) begin
					out_q <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/pctd_checker.sv =====
// Port-level checker for the strided prime counter, bound to the top level.
// Depends on pctd_pkg and prime_count_trial_division_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "prime_count_trial_division_macros.svh"

module pctd_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                s_tvalid,
	input wire logic                                s_tready,
	input wire logic                                m_tvalid,
	input wire logic                                m_tready,
	input wire logic [pctd_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

	// one transaction in flight: taking one closes the slave side
	`PCTD_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready, "ready after accept")

	// a result appears only as the sequencer returns to idle
	`PCTD_ASSERT_NOW(a_result_at_idle, clk, arst_n, $rose(m_tvalid), s_tready, "result not at idle")

	// stalled result holds
	`PCTD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")

endmodule

bind prime_count_trial_division pctd_checker u_pctd_checker (.*);

`default_nettype wire

// ===== sim/prime_count_trial_division_tb.sv =====
// Self-checking testbench for the strided prime counter prime_count_trial_division.
// Needs pctd_pkg and the top level from rtl; it has its own prime count predictor,
// randomised stream handshakes and a cycle budget that serves as the watchdog.
`timescale 1ns / 1ps

module prime_count_trial_division_tb;

	localparam int unsigned VB     = pctd_pkg::VALUE_BITS_DEF;
	localparam int unsigned IN_W   = ((3 * VB + 7) / 8) * 8;
	localparam int unsigned OUT_W  = pctd_pkg::OUT_DATA_BITS;
	localparam int unsigned PAD_W  = IN_W - 3 * VB;
	localparam logic [VB-1:0] VMAX = {VB{1'b1}};

	// one accepted walk and the count it must produce
	typedef struct packed {
		logic [VB-1:0] first;
		logic [VB-1:0] bound;
		logic [VB-1:0] step;
		logic [VB-1:0] count;
	} walk_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	walk_t            pending_counts[$];
	int unsigned      mismatches   = 0;
	int unsigned      burst_left   = 0;
	longint unsigned  cycle_budget = 0;
	longint unsigned  cycle_count  = 0;
	int unsigned      rx_run_left  = 0;
	bit               rx_stalled   = 1'b1;

	prime_count_trial_division #(
		.VALUE_BITS(VB)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Counts primes among first, first+step, ... below bound. Candidates are held at
	// 64 bits so the walk never wraps. work collects a cycle estimate for the watchdog.
	function automatic logic [VB-1:0] count_primes_in_walk(
		input logic [VB-1:0] first,
		input logic [VB-1:0] bound,
		input logic [VB-1:0] step_in,
		inout longint unsigned work
	);
		longint unsigned cand;
		longint unsigned step;
		longint unsigned d;
		logic [VB-1:0]   found;
		bit              prime;
		found = '0;
		step  = (step_in == '0) ? 64'd1 : 64'(step_in);
		work += 8;
		for (cand = 64'(first); cand < 64'(bound); cand += step) begin
			work += 8;
			if (cand < 2)
				prime = 1'b0;
			else if (cand < 4)
				prime = 1'b1;
			else if ((cand & 1) == 0)
				prime = 1'b0;
			else begin
				prime = 1'b1;
				for (d = 3; d * d <= cand && prime; d += 2) begin
					work += VB + 6;
					if (cand % d == 0)
						prime = 1'b0;
				end
				work += VB + 6;
			end
			if (prime)
				found = found + 1'b1;
		end
		return found;
	endfunction

	// Sends one walk. The sender runs in bursts; between bursts tvalid drops for a
	// random gap (sometimes none). tvalid stays high after the last transaction of a burst
	// until the next call decides to open a gap or the sender is stopped.
	task automatic send_walk(
		input logic [VB-1:0]    first,
		input logic [VB-1:0]    bound,
		input logic [VB-1:0]    step,
		input logic [PAD_W-1:0] pad = '0
	);
		int unsigned gap;
		walk_t       w;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pad, step, bound, first};
		do
			@(posedge clk);
		while (!s_tready);
		w.first = first;
		w.bound = bound;
		w.step  = step;
		w.count = count_primes_in_walk(first, bound, step, cycle_budget);
		cycle_budget += 24;
		pending_counts.insert(pending_counts.size(), w);
		burst_left--;
	endtask

	// Holds the sender off until every outstanding count has come back.
	task automatic wait_all_counts;
		s_tvalid   <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (pending_counts.size() != 0);
	endtask

	// Fixed cases: empty and reversed ranges, 0 and 1, the small primes, zero stride,
	// the top of the field range, strides that would step past it, and set pad bits.
	task automatic test_directed_edges;
		send_walk(0, 0, 1);
		send_walk(0, 2, 1);
		send_walk(0, 10, 1);
		send_walk(2, 3, 1);
		send_walk(4, 5, 1);
		send_walk(5, 5, 1);
		send_walk(100, 50, 3);
		send_walk(0, 30, 0);
		send_walk(0, 200, 2);
		send_walk(1, 200, 2);
		send_walk(VMAX, VMAX, 1);
		send_walk(VMAX, 0, VMAX);
		send_walk(0, VMAX, VMAX);
		send_walk(VMAX - VB'(5), VMAX, 1);
		send_walk(VMAX - VB'(2), VMAX, VMAX);
		send_walk(3, VMAX, VMAX);
		send_walk(1, VMAX, VB'(1) << (VB - 1));
		send_walk(0, 100, 1, {PAD_W{1'b1}});
	endtask

	// Small values and short walks: cheap to run, so most of the random traffic.
	task automatic test_small_ranges(input int unsigned n);
		logic [VB-1:0] first;
		logic [VB-1:0] bound;
		logic [VB-1:0] step;
		repeat (n) begin
			first = VB'($urandom_range(0, 3000));
			if ($urandom_range(0, 7) == 0)
				bound = VB'($urandom_range(0, first));
			else
				bound = first + VB'($urandom_range(0, 60));
			step = ($urandom_range(0, 9) == 0) ? '0 : VB'($urandom_range(1, 6));
			send_walk(first, bound, step);
		end
	endtask

	// Full-width fields so every bit toggles; the walk is clipped to at most eight candidates
	// because each large prime runs the divisor loop up to its square root.
	task automatic test_wide_fields(input int unsigned n);
		logic [VB-1:0]   first;
		logic [VB-1:0]   bound;
		logic [VB-1:0]   step;
		longint unsigned eff_step;
		longint unsigned cap;
		repeat (n) begin
			case ($urandom_range(0, 2))
				0: begin
					first = VB'($urandom_range(0, VMAX));
					bound = VB'($urandom_range(0, VMAX));
					step  = VB'($urandom_range(0, VMAX));
				end
				1: begin
					first = VB'($urandom_range(0, VMAX));
					bound = (longint'(first) + 10 > VMAX) ? VMAX
						: first + VB'($urandom_range(0, 10));
					step  = VB'($urandom_range(1, 3));
				end
				default: begin
					first = VB'($urandom_range(0, 64));
					bound = VB'($urandom_range(0, VMAX));
					step  = VB'($urandom_range(1 << (VB - 2), VMAX));
				end
			endcase
			eff_step = (step == '0) ? 64'd1 : 64'(step);
			cap      = longint'(first) + 8 * eff_step;
			if (64'(bound) > cap)
				bound = VB'(cap);
			send_walk(first, bound, step);
		end
	endtask

	// Sender stops with work in flight and resumes only once the pipe is empty.
	task automatic test_pause_until_drained;
		repeat (4) send_walk(VB'($urandom_range(0, 500)), VB'($urandom_range(0, 600)),
			VB'($urandom_range(1, 4)));
		wait_all_counts();
		repeat (4) send_walk(VB'($urandom_range(0, 500)), VB'($urandom_range(0, 600)),
			VB'($urandom_range(1, 4)));
	endtask

	// Receiver: alternating ready and stall runs, now and then a long ready stretch.
	always @(posedge clk) begin
		if (rx_run_left == 0) begin
			rx_stalled  = !rx_stalled;
			if (rx_stalled)
				rx_run_left = $urandom_range(1, 5);
			else
				rx_run_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 10);
			m_tready <= !rx_stalled;
		end
		rx_run_left--;
	end

	// Compares each result transaction with the oldest pending count.
	always @(posedge clk) begin
		walk_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_counts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: prime_count %0d", m_tdata[VB-1:0]);
			end else begin
				w = pending_counts.pop_front();
				if (m_tdata[VB-1:0] !== w.count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("start %0d limit %0d stride %0d: expected %0d, got %0d",
							w.first, w.bound, w.step, w.count, m_tdata[VB-1:0]);
				end
			end
		end
	end

	// Watchdog: the budget grows with the estimated cost of every accepted walk.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 4 * cycle_budget + 50000) begin
			$display("prime_count_trial_division_tb failed");
			$finish;
		end
	end

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		m_tready <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		wait_all_counts();
		test_small_ranges(50);
		test_pause_until_drained();
		test_wide_fields(35);

		s_tvalid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		// catch any stray result transaction after the last one
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("prime_count_trial_division_tb passed");
		else
			$display("prime_count_trial_division_tb failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pctd_pkg.sv
rtl/prime_count_trial_division.sv
rtl/pctd_checker.sv
sim/prime_count_trial_division_tb.sv
